// ----- src/eed_pkg.sv -----
// Shared types, codes and helper functions for the echo escape decoder.
`timescale 1ns / 1ps

package eed_pkg;

   localparam int CHAR_W      = 21;
   localparam int OP_W        = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 1;
   localparam int MAX_RESULTS = 3;

   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [OP_W-1:0]   op_type;

   // input item op codes
   localparam op_type OP_CHAR = 2'd0;
   localparam op_type OP_ARG  = 2'd1;
   localparam op_type OP_END  = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INTERPRET_ESCAPES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRINT_SPACES      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRINT_NEWLINE     = 2'd2;

   localparam char_type CH_BSLASH  = char_type'(92);
   localparam char_type CH_SPACE   = char_type'(32);
   localparam char_type CH_NEWLINE = char_type'(10);
   localparam char_type CH_ESC     = char_type'(8'h1B);
   localparam char_type CH_X       = char_type'("x");
   localparam char_type CH_C       = char_type'("c");
   localparam char_type CH_ZERO    = char_type'("0");

   typedef struct packed {
      char_type ch;
      logic     raw;
   } rsp_item_type;

   typedef struct packed {
      rsp_item_type [MAX_RESULTS-1:0] item;
      logic [1:0]                     count;
   } rsp_list_type;

   typedef struct packed {
      char_type ch;
      logic     raw;
      logic     last;
   } rsp_entry_type;

   // append one result to the list of this item
   function automatic rsp_list_type push_item(rsp_list_type l, char_type c, logic raw);
      rsp_list_type r;
      r = l;
      if (l.count < 2'(MAX_RESULTS)) begin
         r.item[l.count].ch  = c;
         r.item[l.count].raw = raw;
         r.count             = l.count + 2'd1;
      end
      return r;
   endfunction

   // digit value of c, bit 4 set when c is no digit of the base
   function automatic logic [4:0] digit_of(char_type c, logic hex);
      logic [4:0] d;
      d = 5'd16;
      if (c >= char_type'("0") && c <= char_type'("7")) begin
         d = 5'(c - char_type'("0"));
      end else if (hex) begin
         if (c >= char_type'("8") && c <= char_type'("9")) begin
            d = 5'(c - char_type'("0"));
         end else if (c >= char_type'("a") && c <= char_type'("f")) begin
            d = 5'(c - char_type'("a") + char_type'(10));
         end else if (c >= char_type'("A") && c <= char_type'("F")) begin
            d = 5'(c - char_type'("A") + char_type'(10));
         end
      end
      return d;
   endfunction

endpackage

// ----- src/eed_if.sv -----
// Valid/ready channel interfaces for request and result items.
`timescale 1ns / 1ps

interface eed_req_if;
   logic                valid;
   logic                ready;
   eed_pkg::op_type     op;
   eed_pkg::char_type   ch;

   modport source (output valid, output op, output ch, input ready);
   modport sink   (input valid, input op, input ch, output ready);
endinterface

interface eed_rsp_if;
   logic                valid;
   logic                ready;
   eed_pkg::char_type   out_char;
   logic                raw_byte;
   logic                last;

   modport source (output valid, output out_char, output raw_byte, output last, input ready);
   modport sink   (input valid, input out_char, input raw_byte, input last, output ready);
endinterface

// ----- src/echo_escape_decoder.sv -----
// Echo escape decoder top level: decode stage, state and result queue.
`timescale 1ns / 1ps

// Usage:
// req_chan carries one item per handshake: a character (op char), the start
// of an argument (op arg) or the end of a command (op end). rsp_chan returns
// the decoded characters, one to three per request item, with last set on
// the final one; an item may also produce none (pending escape digits, \c).
// csr_* is a plain write port for interpret_escapes and the space and
// newline enables; write it only while the block is idle.
// An accepted item is held in the input stage registers and decoded there
// once the stage fires; its results are registered in the result queue.
// Throughput: one item per cycle while each item yields at most one result
// and the receiver keeps up. The decode stage fires only when the 4-entry
// result queue has room for a worst-case item (3 results), so items with
// 2 or 3 results cost extra cycles while the queue drains.
// Reset (synchronous) empties the stage and queue, clears escape state,
// the stop flag and argument tracking, and loads the register defaults
// (escapes off, spaces on, newline on).
// When the receiver stalls, the queue fills and req_chan.ready drops; no
// item is lost and results hold steady until taken.

module echo_escape_decoder (
   input  logic                          clock,
   input  logic                          reset,
   eed_req_if.sink                       req_chan,
   eed_rsp_if.source                     rsp_chan,
   input  logic                          csr_we,
   input  logic [eed_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [eed_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int FIFO_DEPTH = 4;

   // escape sequencer state codes
   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_BSL  = 2'd1;
   localparam logic [1:0] MODE_OCT  = 2'd2;
   localparam logic [1:0] MODE_HEX  = 2'd3;

   // configuration
   logic interp_ff, interp_in;
   logic spaces_ff, spaces_in;
   logic newline_ff, newline_in;

   // input stage
   logic              vld_ff, vld_in;
   eed_pkg::op_type   op_ff;
   eed_pkg::char_type ch_ff;
   logic              fire;
   logic              req_take;

   // decoder state
   logic [1:0] mode_ff, mode_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [2:0] lim_ff, lim_in;
   logic [7:0] acc_ff, acc_in;
   logic       stop_ff, stop_in;
   logic       seen_ff, seen_in;

   eed_pkg::rsp_list_type push_list;

   // result queue
   eed_pkg::rsp_entry_type fifo_ff [FIFO_DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;

   // Emits whatever a pending escape stands for at a boundary or on a
   // character that ends it.
   function automatic eed_pkg::rsp_list_type flush_list(eed_pkg::rsp_list_type l,
         logic [1:0] mode, logic [2:0] cnt, logic [7:0] acc);
      eed_pkg::rsp_list_type r;
      r = l;
      unique case (mode)
         MODE_BSL: r = eed_pkg::push_item(r, eed_pkg::CH_BSLASH, 1'b0);
         MODE_OCT: r = eed_pkg::push_item(r, eed_pkg::char_type'(acc), 1'b1);
         MODE_HEX: begin
            if (cnt == 3'd0) begin
               r = eed_pkg::push_item(r, eed_pkg::CH_BSLASH, 1'b0);
               r = eed_pkg::push_item(r, eed_pkg::CH_X, 1'b0);
            end else begin
               r = eed_pkg::push_item(r, eed_pkg::char_type'(acc), 1'b1);
            end
         end
         default: r = l;
      endcase
      return r;
   endfunction

   // ---------------- configuration port ----------------
   always_comb begin
      interp_in  = interp_ff;
      spaces_in  = spaces_ff;
      newline_in = newline_ff;
      if (csr_we) begin
         unique case (csr_index)
            eed_pkg::CSR_INTERPRET_ESCAPES: interp_in  = csr_wdata[0];
            eed_pkg::CSR_PRINT_SPACES:      spaces_in  = csr_wdata[0];
            eed_pkg::CSR_PRINT_NEWLINE:     newline_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------- input stage ----------------
   // The stage fires only when the queue can absorb a worst-case item.
   assign fire           = vld_ff && (count_ff <= 3'(FIFO_DEPTH - eed_pkg::MAX_RESULTS));
   assign req_chan.ready = !vld_ff || fire;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      vld_in = vld_ff;
      if (req_take) begin
         vld_in = 1'b1;
      end else if (fire) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff <= req_chan.op;
         ch_ff <= req_chan.ch;
      end
   end

   // ---------------- decode ----------------
   always_comb begin
      eed_pkg::rsp_list_type l;
      logic [4:0] d;
      logic       hex;
      logic [1:0] mode_v;
      logic [2:0] cnt_v;
      logic [2:0] lim_v;
      logic [7:0] acc_v;
      logic       stop_v;
      logic       seen_v;
      logic       plain_pending;

      l             = '0;
      mode_v        = mode_ff;
      cnt_v         = cnt_ff;
      lim_v         = lim_ff;
      acc_v         = acc_ff;
      stop_v        = stop_ff;
      seen_v        = seen_ff;
      plain_pending = 1'b0;
      hex           = (mode_ff == MODE_HEX);
      d             = eed_pkg::digit_of(ch_ff, hex);

      if (fire) begin
         unique case (op_ff)
            eed_pkg::OP_CHAR: begin
               if (!stop_ff) begin
                  unique case (mode_ff)
                     MODE_BSL: begin
                        mode_v = MODE_IDLE;
                        cnt_v  = 3'd0;
                        lim_v  = 3'd0;
                        acc_v  = 8'd0;
                        case (ch_ff)
                           eed_pkg::char_type'("a"): l = eed_pkg::push_item(l, eed_pkg::char_type'(7), 1'b0);
                           eed_pkg::char_type'("b"): l = eed_pkg::push_item(l, eed_pkg::char_type'(8), 1'b0);
                           eed_pkg::char_type'("e"): l = eed_pkg::push_item(l, eed_pkg::CH_ESC, 1'b0);
                           eed_pkg::char_type'("f"): l = eed_pkg::push_item(l, eed_pkg::char_type'(12), 1'b0);
                           eed_pkg::char_type'("n"): l = eed_pkg::push_item(l, eed_pkg::CH_NEWLINE, 1'b0);
                           eed_pkg::char_type'("r"): l = eed_pkg::push_item(l, eed_pkg::char_type'(13), 1'b0);
                           eed_pkg::char_type'("t"): l = eed_pkg::push_item(l, eed_pkg::char_type'(9), 1'b0);
                           eed_pkg::char_type'("v"): l = eed_pkg::push_item(l, eed_pkg::char_type'(11), 1'b0);
                           eed_pkg::CH_BSLASH:       l = eed_pkg::push_item(l, eed_pkg::CH_BSLASH, 1'b0);
                           eed_pkg::CH_C:            stop_v = 1'b1;
                           eed_pkg::CH_X: begin
                              mode_v = MODE_HEX;
                              lim_v  = 3'd2;
                           end
                           default: begin
                              if (!d[4]) begin
                                 // octal: \0 takes up to 3 more digits
                                 mode_v = MODE_OCT;
                                 lim_v  = (ch_ff == eed_pkg::CH_ZERO) ? 3'd4 : 3'd3;
                                 cnt_v  = 3'd1;
                                 acc_v  = {5'd0, d[2:0]};
                              end else begin
                                 // unknown escape: backslash, then char as usual
                                 l             = eed_pkg::push_item(l, eed_pkg::CH_BSLASH, 1'b0);
                                 plain_pending = 1'b1;
                              end
                           end
                        endcase
                     end
                     MODE_OCT, MODE_HEX: begin
                        if (!d[4] && (cnt_ff < lim_ff)) begin
                           acc_v = hex ? {acc_ff[3:0], d[3:0]}
                                       : ({acc_ff[4:0], 3'd0} + {5'd0, d[2:0]});
                           cnt_v = cnt_ff + 3'd1;
                           if (cnt_v >= lim_ff) begin
                              l      = flush_list(l, mode_ff, cnt_v, acc_v);
                              mode_v = MODE_IDLE;
                              cnt_v  = 3'd0;
                              lim_v  = 3'd0;
                              acc_v  = 8'd0;
                           end
                        end else begin
                           l             = flush_list(l, mode_ff, cnt_ff, acc_ff);
                           mode_v        = MODE_IDLE;
                           cnt_v         = 3'd0;
                           lim_v         = 3'd0;
                           acc_v         = 8'd0;
                           plain_pending = 1'b1;
                        end
                     end
                     default: begin
                        mode_v        = MODE_IDLE;
                        cnt_v         = 3'd0;
                        lim_v         = 3'd0;
                        acc_v         = 8'd0;
                        plain_pending = 1'b1;
                     end
                  endcase

                  // ordinary character handling in the idle state
                  if (plain_pending) begin
                     if (interp_ff && (ch_ff == eed_pkg::CH_BSLASH)) begin
                        mode_v = MODE_BSL;
                     end else begin
                        l = eed_pkg::push_item(l, ch_ff, 1'b0);
                     end
                  end
               end
            end
            eed_pkg::OP_ARG: begin
               l      = flush_list(l, mode_ff, cnt_ff, acc_ff);
               mode_v = MODE_IDLE;
               cnt_v  = 3'd0;
               lim_v  = 3'd0;
               acc_v  = 8'd0;
               if (!stop_ff && spaces_ff && seen_ff) begin
                  l = eed_pkg::push_item(l, eed_pkg::CH_SPACE, 1'b0);
               end
               seen_v = 1'b1;
            end
            eed_pkg::OP_END: begin
               l      = flush_list(l, mode_ff, cnt_ff, acc_ff);
               mode_v = MODE_IDLE;
               cnt_v  = 3'd0;
               lim_v  = 3'd0;
               acc_v  = 8'd0;
               if (!stop_ff && newline_ff) begin
                  l = eed_pkg::push_item(l, eed_pkg::CH_NEWLINE, 1'b0);
               end
               stop_v = 1'b0;
               seen_v = 1'b0;
            end
            default: ; // undefined op: ignored
         endcase
      end

      push_list = l;
      mode_in   = mode_v;
      cnt_in    = cnt_v;
      lim_in    = lim_v;
      acc_in    = acc_v;
      stop_in   = stop_v;
      seen_in   = seen_v;
   end

   // ---------------- result queue ----------------
   assign pop = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_list.count;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, push_list.count} - {2'd0, pop};
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < eed_pkg::MAX_RESULTS; i++) begin
         if (2'(i) < push_list.count) begin
            fifo_ff[wr_ptr_ff + 2'(i)].ch   <= push_list.item[i].ch;
            fifo_ff[wr_ptr_ff + 2'(i)].raw  <= push_list.item[i].raw;
            fifo_ff[wr_ptr_ff + 2'(i)].last <= (2'(i) == (push_list.count - 2'd1));
         end
      end
   end

   assign rsp_chan.valid    = (count_ff != 3'd0);
   assign rsp_chan.out_char = fifo_ff[rd_ptr_ff].ch;
   assign rsp_chan.raw_byte = fifo_ff[rd_ptr_ff].raw;
   assign rsp_chan.last     = fifo_ff[rd_ptr_ff].last;

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         interp_ff  <= 1'b0;
         spaces_ff  <= 1'b1;
         newline_ff <= 1'b1;
         vld_ff     <= 1'b0;
         mode_ff    <= MODE_IDLE;
         cnt_ff     <= 3'd0;
         lim_ff     <= 3'd0;
         acc_ff     <= 8'd0;
         stop_ff    <= 1'b0;
         seen_ff    <= 1'b0;
         wr_ptr_ff  <= 2'd0;
         rd_ptr_ff  <= 2'd0;
         count_ff   <= 3'd0;
      end else begin
         interp_ff  <= interp_in;
         spaces_ff  <= spaces_in;
         newline_ff <= newline_in;
         vld_ff     <= vld_in;
         mode_ff    <= mode_in;
         cnt_ff     <= cnt_in;
         lim_ff     <= lim_in;
         acc_ff     <= acc_in;
         stop_ff    <= stop_in;
         seen_ff    <= seen_in;
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         count_ff   <= count_in;
      end
   end

   // ---------------- assertions ----------------
   // queue never overflows
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(FIFO_DEPTH))
      else $error("result queue overflow");

   // stopped output produces no results for any op
   a_stop_silent: assert property (@(posedge clock) disable iff (reset)
      (fire && stop_ff) |-> (push_list.count == 2'd0))
      else $error("result produced while output stopped");

   // command end returns the decoder to its idle state
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && op_ff == eed_pkg::OP_END) |=>
         (mode_ff == MODE_IDLE && !stop_ff && !seen_ff && acc_ff == 8'd0))
      else $error("command end left decoder state behind");

endmodule

// ----- tb/echo_escape_decoder_tb.sv -----
// Self-checking testbench for the echo escape decoder: random valid/ready traffic, scoreboard.
`timescale 1ns / 1ps

module echo_escape_decoder_tb;

   // op code 3 is undefined; the block must ignore it
   localparam eed_pkg::op_type OP_UNUSED     = 2'd3;
   localparam int              HOLD_CYCLES   = 300;
   localparam int              SETTLE_CYCLES = 6;

   typedef enum logic [2:0] {
      ESC_IDLE,
      ESC_BACKSLASH,
      ESC_OCTAL,
      ESC_HEX
   } esc_mode_type;

   typedef struct packed {
      eed_pkg::op_type   op;
      eed_pkg::char_type ch;
   } req_item_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_we;
   logic [eed_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [eed_pkg::CSR_DATA_W-1:0] csr_wdata;

   eed_req_if req_chan ();
   eed_rsp_if rsp_chan ();

   echo_escape_decoder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Decoder model: config copy, escape state and the expected result store
   // ---------------------------------------------------------------------
   logic         cfg_escapes, cfg_spaces, cfg_newline;
   esc_mode_type esc_mode;
   logic [2:0]   dig_cnt, dig_lim;
   logic [7:0]   acc_val;
   logic         stopped, arg_seen;

   eed_pkg::rsp_entry_type step_out[$];        // results of the item being decoded
   eed_pkg::rsp_entry_type expected_chars[$];  // results still owed by the block

   function automatic void reset_model();
      cfg_escapes = 1'b0;
      cfg_spaces  = 1'b1;
      cfg_newline = 1'b1;
      esc_mode    = ESC_IDLE;
      dig_cnt     = '0;
      dig_lim     = '0;
      acc_val     = '0;
      stopped     = 1'b0;
      arg_seen    = 1'b0;
   endfunction

   function automatic void clear_escape();
      esc_mode = ESC_IDLE;
      dig_cnt  = '0;
      dig_lim  = '0;
      acc_val  = '0;
   endfunction

   function automatic void put_char(eed_pkg::char_type c, logic raw);
      eed_pkg::rsp_entry_type e;
      e.ch   = c;
      e.raw  = raw;
      e.last = 1'b0;
      if (step_out.size() < eed_pkg::MAX_RESULTS) begin
         step_out.insert(step_out.size(), e);
      end
   endfunction

   // 0..15 for a digit of the base, 16 otherwise
   function automatic int digit_value(eed_pkg::char_type c, logic hex);
      if (c >= eed_pkg::char_type'("0") && c <= eed_pkg::char_type'("7")) begin
         return int'(c - eed_pkg::char_type'("0"));
      end
      if (!hex) begin
         return 16;
      end
      if (c >= eed_pkg::char_type'("8") && c <= eed_pkg::char_type'("9")) begin
         return int'(c - eed_pkg::char_type'("0"));
      end
      if (c >= eed_pkg::char_type'("a") && c <= eed_pkg::char_type'("f")) begin
         return int'(c - eed_pkg::char_type'("a")) + 10;
      end
      if (c >= eed_pkg::char_type'("A") && c <= eed_pkg::char_type'("F")) begin
         return int'(c - eed_pkg::char_type'("A")) + 10;
      end
      return 16;
   endfunction

   // a pending sequence gives up what it holds so far
   function automatic void flush_escape();
      case (esc_mode)
         ESC_BACKSLASH: put_char(eed_pkg::CH_BSLASH, 1'b0);
         ESC_OCTAL:     put_char(eed_pkg::char_type'(acc_val), 1'b1);
         ESC_HEX: begin
            if (dig_cnt == 0) begin
               put_char(eed_pkg::CH_BSLASH, 1'b0);
               put_char(eed_pkg::CH_X, 1'b0);
            end else begin
               put_char(eed_pkg::char_type'(acc_val), 1'b1);
            end
         end
         default: ;
      endcase
      clear_escape();
   endfunction

   function automatic void plain_char(eed_pkg::char_type c);
      if (cfg_escapes && c == eed_pkg::CH_BSLASH) begin
         esc_mode = ESC_BACKSLASH;
      end else begin
         put_char(c, 1'b0);
      end
   endfunction

   function automatic void after_backslash(eed_pkg::char_type c);
      eed_pkg::char_type m;
      logic              hit;
      int                d;
      m   = '0;
      hit = 1'b1;
      case (c)
         eed_pkg::char_type'("a"): m = eed_pkg::char_type'(7);
         eed_pkg::char_type'("b"): m = eed_pkg::char_type'(8);
         eed_pkg::char_type'("e"): m = eed_pkg::CH_ESC;
         eed_pkg::char_type'("f"): m = eed_pkg::char_type'(12);
         eed_pkg::char_type'("n"): m = eed_pkg::CH_NEWLINE;
         eed_pkg::char_type'("r"): m = eed_pkg::char_type'(13);
         eed_pkg::char_type'("t"): m = eed_pkg::char_type'(9);
         eed_pkg::char_type'("v"): m = eed_pkg::char_type'(11);
         eed_pkg::CH_BSLASH:       m = eed_pkg::CH_BSLASH;
         default:                  hit = 1'b0;
      endcase
      d = digit_value(c, 1'b0);
      if (hit) begin
         clear_escape();
         put_char(m, 1'b0);
      end else if (c == eed_pkg::CH_C) begin
         clear_escape();
         stopped = 1'b1;
      end else if (d < 16) begin
         esc_mode = ESC_OCTAL;
         dig_lim  = (c == eed_pkg::CH_ZERO) ? 3'd4 : 3'd3;
         dig_cnt  = 3'd1;
         acc_val  = 8'(d);
      end else if (c == eed_pkg::CH_X) begin
         esc_mode = ESC_HEX;
         dig_lim  = 3'd2;
         dig_cnt  = 3'd0;
         acc_val  = '0;
      end else begin
         // unknown escape: backslash out, then c as an ordinary char
         clear_escape();
         put_char(eed_pkg::CH_BSLASH, 1'b0);
         plain_char(c);
      end
   endfunction

   function automatic void numeric_char(eed_pkg::char_type c);
      logic hex;
      int   d;
      hex = (esc_mode == ESC_HEX);
      d   = digit_value(c, hex);
      if (d < 16 && dig_cnt < dig_lim) begin
         acc_val = 8'((int'(acc_val) << (hex ? 4 : 3)) + d);
         dig_cnt = dig_cnt + 3'd1;
         if (dig_cnt >= dig_lim) begin
            flush_escape();
         end
      end else begin
         flush_escape();
         plain_char(c);
      end
   endfunction

   // decode one accepted item and queue the results it owes
   function automatic void decode_item(eed_pkg::op_type op, eed_pkg::char_type c);
      eed_pkg::rsp_entry_type e;
      step_out.delete();
      case (op)
         eed_pkg::OP_CHAR: begin
            if (!stopped) begin
               if (esc_mode == ESC_BACKSLASH) begin
                  after_backslash(c);
               end else if (esc_mode == ESC_OCTAL || esc_mode == ESC_HEX) begin
                  numeric_char(c);
               end else begin
                  clear_escape();
                  plain_char(c);
               end
            end
         end
         eed_pkg::OP_ARG: begin
            flush_escape();
            if (!stopped && cfg_spaces && arg_seen) begin
               put_char(eed_pkg::CH_SPACE, 1'b0);
            end
            arg_seen = 1'b1;
         end
         eed_pkg::OP_END: begin
            flush_escape();
            if (!stopped && cfg_newline) begin
               put_char(eed_pkg::CH_NEWLINE, 1'b0);
            end
            stopped  = 1'b0;
            arg_seen = 1'b0;
         end
         default: ;
      endcase
      for (int i = 0; i < step_out.size(); i++) begin
         e      = step_out[i];
         e.last = (i == step_out.size() - 1);
         expected_chars.insert(expected_chars.size(), e);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Scoreboard
   // ---------------------------------------------------------------------
   int err_count     = 0;
   int items_taken   = 0;
   int ignored_taken = 0;
   int results_seen  = 0;
   int raw_seen      = 0;

   task automatic report_mismatch(string what);
      $display("%0t ns: MISMATCH %s", $realtime, what);
      err_count++;
   endtask

   task automatic check_result(eed_pkg::char_type c, logic raw, logic last);
      eed_pkg::rsp_entry_type e;
      if (expected_chars.size() == 0) begin
         report_mismatch($sformatf("result %0h with none expected", c));
      end else begin
         e = expected_chars.pop_front();
         if (c !== e.ch) begin
            report_mismatch($sformatf("out_char %0h, expected %0h", c, e.ch));
         end
         if (raw !== e.raw) begin
            report_mismatch($sformatf("raw_byte %0b, expected %0b (char %0h)", raw, e.raw, e.ch));
         end
         if (last !== e.last) begin
            report_mismatch($sformatf("last %0b, expected %0b (char %0h)", last, e.last, e.ch));
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Driver, receiver and monitor
   // ---------------------------------------------------------------------
   req_item_type pending[$];
   logic req_took    = 1'b0;  // handshake seen at the last rising edge
   logic tx_idle_on  = 1'b1;
   logic rx_idle_on  = 1'b1;
   int   gap_left    = 0;
   int   stall_left  = 0;
   int   hold_left   = 0;
   int   hold_asks   = 0;
   int   hold_done   = 0;

   // sender: new item only when the bus is free or the last one was taken
   always @(negedge clock) begin
      req_item_type it;
      if (!req_chan.valid || req_took) begin
         if (gap_left > 0) begin
            gap_left--;
            req_chan.valid <= 1'b0;
         end else if (tx_idle_on && pending.size() != 0 && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(0, 18);
            req_chan.valid <= 1'b0;
         end else if (pending.size() != 0) begin
            it = pending.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.op    <= it.op;
            req_chan.ch    <= it.ch;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // receiver: long hold on request, otherwise random stall bursts
   always @(negedge clock) begin
      if (hold_asks != hold_done) begin
         hold_done++;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 18);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // monitor: predict on every accepted item, check every accepted result
   always @(posedge clock) begin
      req_took = !reset && req_chan.valid && req_chan.ready;
      if (req_took) begin
         decode_item(req_chan.op, req_chan.ch);
         if (req_chan.op == OP_UNUSED) begin
            ignored_taken++;
         end else begin
            items_taken++;
         end
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (rsp_chan.raw_byte) begin
            raw_seen++;
         end
         check_result(rsp_chan.out_char, rsp_chan.raw_byte, rsp_chan.last);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   int queued_items = 0;  // real items queued (undefined op not counted)

   eed_pkg::char_type single_escapes [0:8] = '{
      eed_pkg::char_type'("a"), eed_pkg::char_type'("b"), eed_pkg::char_type'("e"),
      eed_pkg::char_type'("f"), eed_pkg::char_type'("n"), eed_pkg::char_type'("r"),
      eed_pkg::char_type'("t"), eed_pkg::char_type'("v"), eed_pkg::CH_BSLASH
   };

   function automatic void queue_req(eed_pkg::op_type op, eed_pkg::char_type c);
      req_item_type it;
      it.op = op;
      it.ch = c;
      pending.insert(pending.size(), it);
      if (op != OP_UNUSED) begin
         queued_items++;
      end
   endfunction

   function automatic void queue_char(eed_pkg::char_type c);
      queue_req(eed_pkg::OP_CHAR, c);
   endfunction

   function automatic eed_pkg::char_type octal_digit();
      return eed_pkg::CH_ZERO + eed_pkg::char_type'($urandom_range(0, 7));
   endfunction

   function automatic eed_pkg::char_type hex_digit();
      int d;
      d = $urandom_range(0, 15);
      if (d < 10) begin
         return eed_pkg::CH_ZERO + eed_pkg::char_type'(d);
      end
      if ($urandom_range(0, 1) == 1) begin
         return eed_pkg::char_type'("a") + eed_pkg::char_type'(d - 10);
      end
      return eed_pkg::char_type'("A") + eed_pkg::char_type'(d - 10);
   endfunction

   function automatic eed_pkg::char_type printable();
      return eed_pkg::char_type'($urandom_range(32, 126));
   endfunction

   // one escape sequence, well formed or cut short
   function automatic void gen_escape();
      int k;
      int n;
      queue_char(eed_pkg::CH_BSLASH);
      k = $urandom_range(0, 15);
      if (k < 5) begin
         queue_char(single_escapes[$urandom_range(0, 8)]);
      end else if (k < 8) begin
         queue_char(eed_pkg::CH_ZERO);
         n = $urandom_range(0, 4);
         repeat (n) queue_char(octal_digit());
      end else if (k < 10) begin
         n = $urandom_range(1, 4);
         repeat (n) queue_char(octal_digit());
      end else if (k < 13) begin
         queue_char(eed_pkg::CH_X);
         n = $urandom_range(0, 3);
         repeat (n) queue_char(hex_digit());
      end else if (k < 15) begin
         queue_char(printable());
      end else if ($urandom_range(0, 3) == 0) begin
         queue_char(eed_pkg::CH_C);
      end else begin
         queue_char(eed_pkg::char_type'("8") + eed_pkg::char_type'($urandom_range(0, 1)));
      end
   endfunction

   // one command: mostly well formed, with noise and open endings mixed in
   function automatic void gen_command();
      int n_tok;
      if ($urandom_range(0, 3) != 0) begin
         queue_req(eed_pkg::OP_ARG, eed_pkg::char_type'($urandom));
      end
      n_tok = $urandom_range(1, 7);
      repeat (n_tok) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: queue_char(printable());
            4:          queue_req(eed_pkg::OP_ARG, eed_pkg::char_type'($urandom));
            9: begin
               if ($urandom_range(0, 1) == 1) begin
                  queue_req(OP_UNUSED, eed_pkg::char_type'($urandom));
               end else begin
                  queue_char(eed_pkg::char_type'($urandom));
               end
            end
            default:    gen_escape();
         endcase
      end
      if ($urandom_range(0, 15) != 0) begin
         queue_req(eed_pkg::OP_END, eed_pkg::char_type'($urandom));
      end
   endfunction

   task automatic csr_write(logic [eed_pkg::CSR_IDX_W-1:0] idx, logic val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         eed_pkg::CSR_INTERPRET_ESCAPES: cfg_escapes = val;
         eed_pkg::CSR_PRINT_SPACES:      cfg_spaces  = val;
         eed_pkg::CSR_PRINT_NEWLINE:     cfg_newline = val;
         default: ;
      endcase
   endtask

   // block must be idle here; flags change on a rising edge, away from the drivers
   task automatic set_mode(logic esc, logic sp, logic nl, logic tx_idle, logic rx_idle);
      csr_write(eed_pkg::CSR_INTERPRET_ESCAPES, esc);
      csr_write(eed_pkg::CSR_PRINT_SPACES, sp);
      csr_write(eed_pkg::CSR_PRINT_NEWLINE, nl);
      @(posedge clock);
      tx_idle_on = tx_idle;
      rx_idle_on = rx_idle;
   endtask

   // all queued items taken, all results in, then a settling wait for items
   // that produce nothing but may still be in the decode stage
   task automatic wait_idle();
      do @(posedge clock);
      while (pending.size() != 0 || req_chan.valid || expected_chars.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_random(int n_items, logic long_hold);
      int goal;
      if (long_hold) begin
         hold_asks++;
      end
      goal = queued_items + n_items;
      while (queued_items < goal) begin
         gen_command();
      end
      wait_idle();
   endtask

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = eed_pkg::CSR_INTERPRET_ESCAPES;
      csr_wdata      = '0;
      req_chan.valid = 1'b0;
      req_chan.op    = eed_pkg::OP_CHAR;
      req_chan.ch    = '0;
      rsp_chan.ready = 1'b0;
      reset_model();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      // reset defaults, escapes off: extremes of ch, a backslash passed as is,
      // chars ahead of the first argument start, the undefined op
      queue_char('0);
      queue_char('1);
      queue_char(eed_pkg::CH_BSLASH);
      queue_req(eed_pkg::OP_ARG, '0);
      queue_req(OP_UNUSED, '1);
      queue_req(eed_pkg::OP_ARG, '1);
      queue_req(eed_pkg::OP_END, '0);
      wait_idle();

      csr_write(eed_pkg::CSR_INTERPRET_ESCAPES, 1'b1);
      @(posedge clock);
      queue_req(eed_pkg::OP_ARG, '0);
      // \0177: octal escape closed by its digit limit
      queue_char(eed_pkg::CH_BSLASH);
      queue_char(eed_pkg::CH_ZERO);
      queue_char(eed_pkg::char_type'("1"));
      queue_char(eed_pkg::char_type'("7"));
      queue_char(eed_pkg::char_type'("7"));
      // \xA then a non-digit that ends it
      queue_char(eed_pkg::CH_BSLASH);
      queue_char(eed_pkg::CH_X);
      queue_char(eed_pkg::char_type'("A"));
      queue_char(eed_pkg::char_type'("z"));
      // \x without digits, then a lone backslash flushed by an argument start
      queue_char(eed_pkg::CH_BSLASH);
      queue_char(eed_pkg::CH_X);
      queue_char(eed_pkg::CH_BSLASH);
      queue_req(eed_pkg::OP_ARG, '0);
      // \x flushed by command end: three results from one item
      queue_char(eed_pkg::CH_BSLASH);
      queue_char(eed_pkg::CH_X);
      queue_req(eed_pkg::OP_END, '0);
      // \c silences the newline (the argument start is the first, so no space)
      queue_char(eed_pkg::CH_BSLASH);
      queue_char(eed_pkg::CH_C);
      queue_req(eed_pkg::OP_ARG, '0);
      queue_req(eed_pkg::OP_END, '0);
      // leave a backslash pending across the config change
      queue_char(eed_pkg::CH_BSLASH);
      wait_idle();

      // escapes off now, yet the pending sequence still decodes \n
      set_mode(1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
      queue_char(eed_pkg::char_type'("n"));
      run_random(50, 1'b0);

      // receiver holds off while the sender streams without gaps
      set_mode(1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
      run_random(60, 1'b1);

      set_mode(1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
      run_random(60, 1'b0);

      set_mode(1'b1, 1'b1, 1'b0, 1'b1, 1'b1);
      run_random(60, 1'b0);

      // final stretch at full rate on both sides
      set_mode(1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
      run_random(50, 1'b0);

      $display("Covered %0d items (+%0d undefined ops), %0d results checked, %0d raw bytes",
               items_taken, ignored_taken, results_seen, raw_seen);
      $display("Modes: escapes on/off, spaces on/off, newline on/off, %0d-cycle output hold",
               HOLD_CYCLES);
      if (err_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
